FILE: src/pidl_pkg.sv
// Package for the positional insert/delete list.
// Holds request function codes and result status codes; no dependencies.
package pidl_pkg;

    typedef enum logic [2:0] {
        FN_APPEND   = 3'd0,
        FN_INSERT   = 3'd1,
        FN_DEL_LAST = 3'd2,
        FN_DEL_AT   = 3'd3,
        FN_READ     = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NOPOS = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

endpackage

FILE: src/positional_insert_delete_list.sv
// Bounded ordered list with insert, delete and read at a 1-based position.
// Depends on pidl_pkg for function and status codes.
//
//  channel   | direction | handshake             | payload
//  ----------+-----------+-----------------------+--------------------------------
//  request   | in        | start & !busy         | func, position, value
//  result    | out       | done (one-cycle pulse)| status, item_count, read_value
//
// A request is registered at the accepting edge; the next edge updates the list
// and registers the result, and done pulses together with that registered result.
// busy stays low: one request is taken every cycle, each sees all earlier ones.
// Every insert, append or positional delete shifts the cells from its slot up in parallel.
// Reset clears the count and the control flops; cell contents are left as is.
// The receiver cannot stall: each result is shown for exactly one cycle.
module positional_insert_delete_list
    import pidl_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         func,
    input  logic [4:0]         position,
    input  logic signed [31:0] value,
    output logic               done,
    output logic [1:0]         status,
    output logic [4:0]         item_count,
    output logic signed [31:0] read_value
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int IW   = $clog2(DEPTH);
    localparam int CMPW = ((CW > 5) ? CW : 5) + 1;

    // request register
    logic               req_vld_reg;
    logic [2:0]         func_reg;
    logic [4:0]         pos_reg;
    logic signed [31:0] value_reg;

    // list state
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic signed [31:0] cells_reg  [DEPTH];
    logic signed [31:0] cells_next [DEPTH];

    // result register
    logic               done_reg;
    status_t            status_reg;
    status_t            status_next;
    logic signed [31:0] rd_reg;
    logic signed [31:0] rd_next;

    logic            do_open;
    logic            do_close;
    logic [CMPW-1:0] slot;
    logic [CMPW-1:0] pos_ext;
    logic [CMPW-1:0] cnt_ext;
    logic            is_full;
    logic            is_empty;
    logic            pos_bad_rd;
    logic            pos_bad_ins;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_vld_reg <= 1'b0;
        end
        else
        begin
            req_vld_reg <= start & ~busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start & ~busy)
        begin
            func_reg  <= func;
            pos_reg   <= position;
            value_reg <= value;
        end
    end

    assign pos_ext     = CMPW'(pos_reg);
    assign cnt_ext     = CMPW'(count_reg);
    assign is_full     = (cnt_ext == CMPW'(DEPTH));
    assign is_empty    = (count_reg == '0);
    assign pos_bad_rd  = (pos_reg == '0) || (pos_ext > cnt_ext);
    assign pos_bad_ins = (pos_reg == '0) || (pos_ext > (cnt_ext + CMPW'(1)));

    always_comb
    begin
        status_next = ST_OK;
        rd_next     = '0;
        do_open     = 1'b0;
        do_close    = 1'b0;
        slot        = pos_ext - CMPW'(1);
        count_next  = count_reg;
        case (func_reg)
            FN_APPEND:
            begin
                slot = cnt_ext;
                if (is_full)
                    status_next = ST_FULL;
                else
                    do_open = 1'b1;
            end
            FN_INSERT:
            begin
                if (pos_bad_ins)
                    status_next = ST_NOPOS;
                else if (is_full)
                    status_next = ST_FULL;
                else
                    do_open = 1'b1;
            end
            FN_DEL_LAST:
            begin
                if (is_empty)
                    status_next = ST_EMPTY;
                else
                    count_next = count_reg - CW'(1);
            end
            FN_DEL_AT:
            begin
                if (is_empty)
                    status_next = ST_EMPTY;
                else if (pos_bad_rd)
                    status_next = ST_NOPOS;
                else
                    do_close = 1'b1;
            end
            FN_READ:
            begin
                if (pos_bad_rd)
                    status_next = ST_NOPOS;
                else
                    rd_next = cells_reg[slot[IW-1:0]];
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
        if (do_open)
            count_next = count_reg + CW'(1);
        else if (do_close)
            count_next = count_reg - CW'(1);
    end

    // each cell keeps its own value, takes the new value at the slot or its lower
    // neighbor above the slot on insert, or its upper neighbor on delete
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        always_comb
        begin
            cells_next[i] = cells_reg[i];
            if (do_open)
            begin
                if (CMPW'(i) == slot)
                    cells_next[i] = value_reg;
                else if (CMPW'(i) > slot)
                begin
                    if (i > 0)
                        cells_next[i] = cells_reg[(i > 0) ? i - 1 : 0];
                end
            end
            else if (do_close)
            begin
                if ((CMPW'(i) >= slot) && (i < DEPTH - 1))
                    cells_next[i] = cells_reg[(i < DEPTH - 1) ? i + 1 : i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (req_vld_reg)
                cells_reg[i] <= cells_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= req_vld_reg;
            if (req_vld_reg)
                count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_vld_reg)
        begin
            status_reg <= status_next;
            rd_reg     <= rd_next;
        end
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign item_count = 5'(count_reg);
    assign read_value = rd_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMPW'(count_reg) <= CMPW'(DEPTH))
        else $error("list count exceeds depth");

    a_done_follows_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_vld_reg |=> done_reg)
        else $error("registered request produced no result");

    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        !req_vld_reg |=> !done_reg)
        else $error("result strobe without a request");

    a_count_change_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (done_reg && status_reg == ST_OK))
        else $error("count changed without a successful transaction");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg == ST_FULL) |-> (CMPW'(count_reg) == CMPW'(DEPTH)))
        else $error("full status reported on a list that is not full");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for positional_insert_delete_list.
// Depends on pidl_pkg and the RTL; a scoreboard class predicts every result.
`timescale 1ns / 1ps

module testbench
    import pidl_pkg::*;
();

    localparam int LIST_DEPTH  = 16;
    localparam int NUM_RANDOM  = 1230;
    localparam int IDLE_LIMIT  = 2000;

    typedef enum int {
        MODE_GROW,
        MODE_SHRINK,
        MODE_MIXED
    } traffic_mode_t;

    typedef struct {
        status_t            status;
        logic [4:0]         count;
        logic signed [31:0] data;
    } list_result_t;

    class list_scoreboard;
        logic signed [31:0] cells [LIST_DEPTH];
        int unsigned        held;
        list_result_t       pending_results [$];
        int unsigned        error_count;

        function new();
            held        = 0;
            error_count = 0;
        endfunction

        function void report_mismatch(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            error_count++;
        endfunction

        function void open_gap(int unsigned idx, logic signed [31:0] val);
            for (int unsigned i = held; i > idx; i--)
                cells[i] = cells[i - 1];
            cells[idx] = val;
            held++;
        endfunction

        function void close_gap(int unsigned idx);
            for (int unsigned i = idx; i + 1 < held; i++)
                cells[i] = cells[i + 1];
            held--;
        endfunction

        // Apply one accepted transaction and queue the result it must produce.
        function void note_request(logic [2:0] fn, logic [4:0] pos, logic signed [31:0] val);
            list_result_t exp_r;
            exp_r.status = ST_OK;
            exp_r.data   = '0;
            case (fn)
                FN_APPEND:
                    if (held >= LIST_DEPTH)
                        exp_r.status = ST_FULL;
                    else
                        open_gap(held, val);
                FN_INSERT:
                    if (pos == 0 || pos > held + 1)
                        exp_r.status = ST_NOPOS;
                    else if (held >= LIST_DEPTH)
                        exp_r.status = ST_FULL;
                    else
                        open_gap(pos - 1, val);
                FN_DEL_LAST:
                    if (held == 0)
                        exp_r.status = ST_EMPTY;
                    else
                        held--;
                FN_DEL_AT:
                    if (held == 0)
                        exp_r.status = ST_EMPTY;
                    else if (pos == 0 || pos > held)
                        exp_r.status = ST_NOPOS;
                    else
                        close_gap(pos - 1);
                FN_READ:
                    if (pos == 0 || pos > held)
                        exp_r.status = ST_NOPOS;
                    else
                        exp_r.data = cells[pos - 1];
                default:
                    ;
            endcase
            exp_r.count = held[4:0];
            pending_results.push_back(exp_r);
        endfunction

        function void check_result(logic [1:0] st, logic [4:0] cnt, logic signed [31:0] rd);
            list_result_t exp_r;
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result status=%0d count=%0d value=%0d",
                                          st, cnt, rd));
                return;
            end
            exp_r = pending_results.pop_front();
            if (st !== exp_r.status)
                report_mismatch($sformatf("status %0d, expected %0d", st, exp_r.status));
            if (cnt !== exp_r.count)
                report_mismatch($sformatf("item_count %0d, expected %0d", cnt, exp_r.count));
            if (rd !== exp_r.data)
                report_mismatch($sformatf("read_value %0d, expected %0d", rd, exp_r.data));
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         func;
    logic [4:0]         position;
    logic signed [31:0] value;
    logic               done;
    logic [1:0]         status;
    logic [4:0]         item_count;
    logic signed [31:0] read_value;

    list_scoreboard sb = new();
    int unsigned    idle_cycles = 0;

    positional_insert_delete_list #(
        .DEPTH(LIST_DEPTH)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .func       (func),
        .position   (position),
        .value      (value),
        .done       (done),
        .status     (status),
        .item_count (item_count),
        .read_value (read_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Note accepted transactions first, so a result is always checked against a queued one.
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            sb.note_request(func, position, value);
        if (rst_n && done)
            sb.check_result(status, item_count, read_value);
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Idle for the given number of cycles, then stop at the next falling edge.
    task wait_gap(input int unsigned gap);
        repeat (gap)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
    endtask

    task drive_request(input logic [2:0] fn, input logic [4:0] pos,
                       input logic signed [31:0] val);
        start    <= 1'b1;
        func     <= fn;
        position <= pos;
        value    <= val;
        do
            @(posedge clk);
        while (busy);
    endtask

    task issue(input logic [2:0] fn, input logic [4:0] pos, input logic signed [31:0] val);
        wait_gap($urandom_range(2));
        drive_request(fn, pos, val);
    endtask

    function automatic logic signed [31:0] pick_value();
        logic signed [31:0] corners [4];
        corners[0] = 32'sh8000_0000;
        corners[1] = 32'sh7fff_ffff;
        corners[2] = 32'sh0000_0000;
        corners[3] = -32'sd1;
        if ($urandom_range(9) == 0)
            return corners[$urandom_range(3)];
        return $urandom;
    endfunction

    // Mostly legal positions, with zero, just past the end and wild values mixed in.
    function automatic logic [4:0] pick_position(bit for_insert);
        int unsigned top;
        int unsigned q;
        top = for_insert ? sb.held + 1 : (sb.held == 0 ? 1 : sb.held);
        q = $urandom_range(9);
        if (q <= 6)
            return 5'($urandom_range(top, 1));
        if (q == 7)
            return 5'd0;
        if (q == 8)
            return 5'(sb.held + 1 + $urandom_range(1));
        return 5'($urandom_range(31));
    endfunction

    function automatic logic [2:0] pick_func(traffic_mode_t mode);
        int unsigned r;
        int unsigned w_app, w_ins, w_rd, w_dl;
        r = $urandom_range(99);
        case (mode)
            MODE_GROW:   begin w_app = 45; w_ins = 30; w_rd = 10; w_dl = 5;  end
            MODE_SHRINK: begin w_app = 10; w_ins = 10; w_rd = 15; w_dl = 25; end
            default:     begin w_app = 20; w_ins = 20; w_rd = 25; w_dl = 15; end
        endcase
        if (r < w_app)
            return FN_APPEND;
        if (r < w_app + w_ins)
            return FN_INSERT;
        if (r < w_app + w_ins + w_rd)
            return FN_READ;
        if (r < w_app + w_ins + w_rd + w_dl)
            return FN_DEL_LAST;
        if (r < 96)
            return FN_DEL_AT;
        // unused codes must leave the list alone
        return 3'($urandom_range(7, 5));
    endfunction

    initial
    begin
        traffic_mode_t      mode;
        int unsigned        gap_style;
        int unsigned        gap;
        logic [2:0]         fn;
        logic [4:0]         pos;
        logic signed [31:0] val;

        rst_n       = 1'b0;
        start       = 1'b0;
        func        = '0;
        position    = '0;
        value       = '0;
        mode        = MODE_MIXED;
        gap_style   = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty list cases, position limits, corner values, unused codes.
        issue(FN_READ,     5'd1, 32'sd0);
        issue(FN_DEL_LAST, 5'd0, 32'sd0);
        issue(FN_DEL_AT,   5'd0, 32'sd0);
        issue(FN_INSERT,   5'd0, 32'sd5);
        issue(FN_INSERT,   5'd2, 32'sd5);
        issue(FN_INSERT,   5'd1, 32'sh7fff_ffff);
        issue(FN_DEL_AT,   5'd1, 32'sd0);
        issue(FN_APPEND,   5'd0, 32'sh8000_0000);
        issue(FN_APPEND,   5'd31, 32'sh7fff_ffff);
        issue(FN_INSERT,   5'd2, -32'sd1);
        issue(FN_INSERT,   5'd4, 32'sd0);
        issue(FN_READ,     5'd0, 32'sd0);
        issue(FN_READ,     5'd5, 32'sd0);
        for (int p = 1; p <= 4; p++)
            issue(FN_READ, 5'(p), 32'sd0);
        issue(FN_DEL_AT,   5'd5, 32'sd0);
        issue(FN_DEL_AT,   5'd2, 32'sd0);
        issue(FN_DEL_LAST, 5'd31, 32'sd0);
        issue(3'd5, 5'd31, -32'sd1);
        issue(3'd6, 5'd16, 32'sd1);
        issue(3'd7, 5'd0,  32'sh5555_aaaa);

        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            if (n % 40 == 0)
            begin
                mode      = traffic_mode_t'($urandom_range(2));
                gap_style = $urandom_range(2);
            end
            // hold off until the list has answered everything
            if (n == NUM_RANDOM / 2 || $urandom_range(149) == 0)
            begin
                @(negedge clk);
                start <= 1'b0;
                while (sb.pending_results.size() != 0)
                    @(posedge clk);
            end
            case (gap_style)
                0:       gap = 0;
                1:       gap = $urandom_range(17);
                default: gap = ($urandom_range(3) == 0) ? $urandom_range(17) : 0;
            endcase
            wait_gap(gap);
            fn  = pick_func(mode);
            pos = pick_position(fn == FN_INSERT);
            val = pick_value();
            drive_request(fn, pos, val);
        end

        @(negedge clk);
        start <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.pending_results.size() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived",
                                         sb.pending_results.size()));
        if (sb.error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
